FILE: rtl/core/sulb_pkg.sv
// Shared types, widths and defaults for the sorted unique list builder.
package sulb_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int NODE_BITS_DEF   = 16;

  localparam int NODE_W  = 16;
  localparam int ROW_W   = 16;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 6;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [NODE_W-1:0] node_index;
    logic [ROW_W-1:0]  row_id;
  } sulb_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row_id_out;
    logic [NODE_W-1:0]  entry_value;
    logic [POS_W-1:0]   entry_position;
    logic [COUNT_W-1:0] entry_count;
    logic               list_empty;
    logic               overflow;
    logic               last;
  } sulb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_FLUSH
  } sulb_state_t;

endpackage

FILE: rtl/core/sulb_entry_ram.sv
// Entry store: one write port, one read port with registered read data.
module sulb_entry_ram #(
  parameter int DEPTH = sulb_pkg::MAX_ENTRIES_DEF,
  parameter int WIDTH = sulb_pkg::NODE_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/sorted_unique_list_builder_top.sv
// Top level: sequencer that keeps one row's neighbor list sorted and unique.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes insert and flush items.
//   An insert adds node_index to the list in ascending order; a value that is
//   already held is ignored, and a new value offered to a full list is dropped
//   and sets the sticky overflow flag. An insert produces no result item.
//   A flush emits the held entries in ascending order on the result channel
//   (out_valid/out_ready/out_data), one item per entry with the count, row and
//   overflow flag, last set on the final one. An empty list gives one item
//   with list_empty set. The flush then clears the list and the flag.
// Timing:
//   One compare unit walks the list one entry per cycle, reading the entry
//   store through its single registered read port and rippling larger entries
//   up through its single write port. An insert holds the block until it has
//   walked all held entries or stopped at a duplicate or on a full list. A
//   flush fetches the first entry when it is taken, then delivers one result
//   per cycle while out_ready is high; a stalled receiver holds the current
//   result and the sequencer. in_ready is high only while the block is idle.
// Reset:
//   Synchronous, active low. Clears the count, the overflow flag and the
//   sequencer; entry storage is not cleared, since only held entries are read.
module sorted_unique_list_builder_top #(
  parameter int MAX_ENTRIES = sulb_pkg::MAX_ENTRIES_DEF,
  parameter int NODE_BITS   = sulb_pkg::NODE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sulb_pkg::sulb_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sulb_pkg::sulb_out_t out_data
);

  import sulb_pkg::*;

  // Stored value width: node bits beyond the 16-bit field never arrive.
  localparam int VW = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  sulb_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          ovf_r, ovf_nxt;
  logic          shift_r, shift_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [VW-1:0] carry_r, carry_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rd_data;

  logic [CW-1:0] k_inc;
  logic          full;
  logic          flush_last;

  sulb_entry_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (VW),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  assign k_inc      = k_r + 1'b1;
  assign full       = (cnt_r == CW'(MAX_ENTRIES));
  assign flush_last = (cnt_r == '0) || (k_inc == cnt_r);

  // Results come straight from registers: row, index, count and read word.
  assign out_data.row_id_out     = row_r;
  assign out_data.entry_value    = (cnt_r == '0) ? '0 : NODE_W'(rd_data);
  assign out_data.entry_position = POS_W'(k_r);
  assign out_data.entry_count    = COUNT_W'(cnt_r);
  assign out_data.list_empty     = (cnt_r == '0);
  assign out_data.overflow       = ovf_r;
  assign out_data.last           = flush_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      k_r     <= '0;
      shift_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      k_r     <= k_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    carry_r <= carry_nxt;
    row_r   <= row_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    k_nxt     = k_r;
    shift_nxt = shift_r;
    val_nxt   = val_r;
    carry_nxt = carry_r;
    row_nxt   = row_r;
    wr_en     = 1'b0;
    wr_addr   = k_r[AW-1:0];
    wr_data   = val_r;
    rd_en     = 1'b0;
    rd_addr   = k_inc[AW-1:0];
    in_ready  = 1'b0;
    out_valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          // Fetch entry 0 now so the walk starts with data in hand.
          rd_en     = 1'b1;
          rd_addr   = '0;
          k_nxt     = '0;
          shift_nxt = 1'b0;
          val_nxt   = in_data.node_index[VW-1:0];
          row_nxt   = in_data.row_id;
          state_nxt = (in_data.req_type == REQ_FLUSH) ? ST_FLUSH : ST_INSERT;
        end
      end

      ST_INSERT: begin
        if (k_r == cnt_r) begin
          // End of the held entries: append the new value or the carried one.
          state_nxt = ST_IDLE;
          wr_addr   = cnt_r[AW-1:0];
          if (shift_r) begin
            wr_en   = 1'b1;
            wr_data = carry_r;
            cnt_nxt = cnt_r + 1'b1;
          end else if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          // Prefetch the next entry while this one is compared.
          rd_en = 1'b1;
          k_nxt = k_inc;
          if (shift_r) begin
            wr_en     = 1'b1;
            wr_data   = carry_r;
            carry_nxt = rd_data;
          end else if (rd_data < val_r) begin
            // Keep searching.
          end else if (rd_data == val_r) begin
            // Drop the duplicate.
            state_nxt = ST_IDLE;
          end else if (full) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            // Place the value here and ripple the larger entries up.
            wr_en     = 1'b1;
            carry_nxt = rd_data;
            shift_nxt = 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (flush_last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            rd_en = 1'b1;
            k_nxt = k_inc;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/sulb_checker.sv
// Port-level checks for the list builder, bound to the top level.
module sulb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input sulb_pkg::sulb_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input sulb_pkg::sulb_out_t out_data
);

  import sulb_pkg::*;

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No new item is taken while a flush is emitting.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted during flush output");

  // Results of one flush follow each other with rising positions.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid &&
      out_data.entry_position == POS_W'($past(out_data.entry_position) + 1'b1))
    else $error("flush position did not advance");

  // An empty flush is a single final result with a zero count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.list_empty |->
      out_data.last && out_data.entry_count == '0)
    else $error("empty flush malformed");

  // An insert never produces a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_INSERT |=> !out_valid)
    else $error("insert produced a result");

endmodule

bind sorted_unique_list_builder_top sulb_checker u_sulb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/sulb_row_list_monitor.sv
// Monitor for the sorted unique list builder: predicts flush results and checks them.
module sulb_row_list_monitor #(
  parameter int MAX_ENTRIES = sulb_pkg::MAX_ENTRIES_DEF,
  parameter int NODE_BITS   = sulb_pkg::NODE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sulb_pkg::sulb_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sulb_pkg::sulb_out_t out_data,
  output int                  mismatch_count,
  output int                  pending_entries,
  output int                  flushes_seen,
  output int                  empty_flushes,
  output int                  overflow_flushes,
  output int                  entries_checked
);
  import sulb_pkg::*;

  logic [NODE_W-1:0] held_nodes [MAX_ENTRIES];
  int                held_total;
  logic              dropped_flag;
  sulb_out_t         expected_entries [$];

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  // Insert in ascending order; ignore duplicates, drop new values when full.
  function automatic void place_node(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] key;
    int                slot;
    for (int b = 0; b < NODE_W; b++) begin
      key[b] = (b < NODE_BITS) ? node[b] : 1'b0;
    end
    slot = 0;
    while (slot < held_total && held_nodes[slot] < key) slot++;
    if (slot < held_total && held_nodes[slot] == key) return;
    if (held_total >= MAX_ENTRIES) begin
      dropped_flag = 1'b1;
      return;
    end
    for (int j = held_total; j > slot; j--) begin
      held_nodes[j] = held_nodes[j-1];
    end
    held_nodes[slot] = key;
    held_total++;
  endfunction

  // Queue one expected entry per held node (or one empty marker), then clear.
  function automatic void queue_row(input logic [ROW_W-1:0] row);
    sulb_out_t entry;
    flushes_seen++;
    if (dropped_flag) overflow_flushes++;
    if (held_total == 0) begin
      entry            = '0;
      entry.row_id_out = row;
      entry.list_empty = 1'b1;
      entry.overflow   = dropped_flag;
      entry.last       = 1'b1;
      expected_entries.push_back(entry);
      empty_flushes++;
    end else begin
      for (int k = 0; k < held_total; k++) begin
        entry.row_id_out     = row;
        entry.entry_value    = held_nodes[k];
        entry.entry_position = k[POS_W-1:0];
        entry.entry_count    = held_total[COUNT_W-1:0];
        entry.list_empty     = 1'b0;
        entry.overflow       = dropped_flag;
        entry.last           = (k == held_total - 1);
        expected_entries.push_back(entry);
      end
    end
    held_total   = 0;
    dropped_flag = 1'b0;
  endfunction

  task automatic check_entry(input sulb_out_t got);
    sulb_out_t want;
    if (expected_entries.size() == 0) begin
      report($sformatf("unexpected result item row %0h value %0h", got.row_id_out,
                       got.entry_value));
      return;
    end
    want = expected_entries.pop_front();
    entries_checked++;
    if (got.row_id_out !== want.row_id_out)
      report($sformatf("row_id_out got %0h want %0h", got.row_id_out, want.row_id_out));
    if (got.entry_value !== want.entry_value)
      report($sformatf("entry_value at pos %0d got %0h want %0h", want.entry_position,
                       got.entry_value, want.entry_value));
    if (got.entry_position !== want.entry_position)
      report($sformatf("entry_position got %0d want %0d", got.entry_position,
                       want.entry_position));
    if (got.entry_count !== want.entry_count)
      report($sformatf("entry_count got %0d want %0d", got.entry_count, want.entry_count));
    if (got.list_empty !== want.list_empty)
      report($sformatf("list_empty got %b want %b", got.list_empty, want.list_empty));
    if (got.overflow !== want.overflow)
      report($sformatf("overflow got %b want %b", got.overflow, want.overflow));
    if (got.last !== want.last)
      report($sformatf("last at pos %0d got %b want %b", want.entry_position, got.last,
                       want.last));
  endtask

  initial begin
    mismatch_count   = 0;
    pending_entries  = 0;
    flushes_seen     = 0;
    empty_flushes    = 0;
    overflow_flushes = 0;
    entries_checked  = 0;
    held_total       = 0;
    dropped_flag     = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      held_total   = 0;
      dropped_flag = 1'b0;
      expected_entries.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_INSERT) place_node(in_data.node_index);
        else queue_row(in_data.row_id);
      end
      if (out_valid && out_ready) check_entry(out_data);
    end
    pending_entries = expected_entries.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
  import sulb_pkg::*;

  localparam int LIST_DEPTH = MAX_ENTRIES_DEF;
  localparam int NODE_WIDTH = NODE_BITS_DEF;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  sulb_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sulb_out_t out_data;

  int mismatch_count;
  int pending_entries;
  int flushes_seen;
  int empty_flushes;
  int overflow_flushes;
  int entries_checked;

  // Sender-side bookkeeping.
  int items_sent      = 0;
  int send_calm       = 0;
  int recv_calm       = 0;
  int long_hold_len   = 0;  // set by the sender, consumed by the receiver
  logic [NODE_W-1:0] row_values [$];

  sorted_unique_list_builder_top #(
    .MAX_ENTRIES(LIST_DEPTH),
    .NODE_BITS  (NODE_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sulb_row_list_monitor #(
    .MAX_ENTRIES(LIST_DEPTH),
    .NODE_BITS  (NODE_WIDTH)
  ) row_watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .pending_entries (pending_entries),
    .flushes_seen    (flushes_seen),
    .empty_flushes   (empty_flushes),
    .overflow_flushes(overflow_flushes),
    .entries_checked (entries_checked)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("sorted_unique_list_builder_top test failed");
    $finish;
  end

  // Draw a random idle gap, with occasional bursts of back-to-back items.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Offer one item and hold it until the block takes it. Valid is only lowered
  // when a gap follows, so back-to-back items keep valid high across the edge.
  task automatic offer(input sulb_in_t item);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Insert item; row_id carries random noise since the block ignores it here.
  task automatic add_node(input logic [NODE_W-1:0] value);
    sulb_in_t item;
    item.req_type   = REQ_INSERT;
    item.node_index = value;
    item.row_id     = ROW_W'($urandom_range(0, 16'hFFFF));
    row_values.push_back(value);
    offer(item);
  endtask

  // Flush item; node_index carries noise.
  task automatic close_row(input logic [ROW_W-1:0] row);
    sulb_in_t item;
    item.req_type   = REQ_FLUSH;
    item.node_index = NODE_W'($urandom_range(0, 16'hFFFF));
    item.row_id     = row;
    row_values.delete();
    offer(item);
  endtask

  // Stop sending and wait until every predicted result item has been taken.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_entries != 0) @(posedge clk);
  endtask

  function automatic logic [NODE_W-1:0] pick_row_value();
    case ($urandom_range(0, 4))
      0: return NODE_W'($urandom_range(0, 15));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2: return (row_values.size() != 0) ?
                row_values[$urandom_range(0, row_values.size() - 1)] :
                NODE_W'($urandom_range(0, 16'hFFFF));
      default: return NODE_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] pick_row_id();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return ROW_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Receiver: for every result item draw a stall, or take a long hold-off
  // when the sender asked for one, counted here in cycles.
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_len > 0) begin
        stall         = long_hold_len;
        long_hold_len = 0;
      end else begin
        stall = draw_gap(recv_calm);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int kind;
    int n;
    int rows_done;
    logic [NODE_W-1:0] start;

    // Hold reset, then release it once.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Flush with nothing held: a single empty marker.
    close_row(16'h0000);

    // Extremes, a duplicate, and values landing between held entries.
    add_node(16'hFFFF);
    add_node(16'h0000);
    add_node(16'h8000);
    add_node(16'h0000);
    add_node(16'h0001);
    add_node(16'h7FFF);
    close_row(16'hFFFF);

    // Values below the first entry with one and with several held.
    add_node(16'd5);
    add_node(16'd3);
    add_node(16'd1);
    add_node(16'd4);
    add_node(16'd3);
    add_node(16'd0);
    close_row(16'h1234);

    // Alternating bit patterns, then two flushes in a row.
    add_node(16'hAAAA);
    add_node(16'h5555);
    close_row(16'h5555);
    close_row(16'hAAAA);
    drain();

    // Random rows. The first one fills the list past capacity and its flush
    // meets a long receiver hold-off while the next row keeps coming.
    items_sent = 0;
    rows_done  = 0;
    while (items_sent < 150) begin
      kind = (rows_done == 0) ? 0 : $urandom_range(0, 9);
      case (kind)
        0: begin
          n = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 6);
          for (int i = 0; i < n; i++) add_node(NODE_W'($urandom_range(0, 16'hFFFF)));
          // Duplicates while full must not set overflow on their own.
          add_node(row_values[$urandom_range(0, row_values.size() - 1)]);
          add_node(row_values[0]);
          if (rows_done == 0) long_hold_len = 300;
          close_row(pick_row_id());
        end
        1: close_row(pick_row_id());
        2: begin
          // Strictly falling values: every insert goes to the front.
          n     = $urandom_range(2, 8);
          start = NODE_W'($urandom_range(20, 16'hFFFF));
          for (int i = 0; i < n; i++) begin
            add_node(NODE_W'(start - i * 2 - $urandom_range(0, 1)));
          end
          close_row(pick_row_id());
        end
        default: begin
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) add_node(pick_row_value());
          close_row(pick_row_id());
        end
      endcase
      rows_done++;
      // Now and then pause until the block has delivered everything.
      if (rows_done % 6 == 0) drain();
    end

    drain();
    repeat (LIST_DEPTH + 10) @(posedge clk);

    $display("Summary: %0d random items, %0d flushes (%0d empty, %0d overflowed),",
             items_sent, flushes_seen, empty_flushes, overflow_flushes);
    $display("         %0d list entries compared, %0d still awaited",
             entries_checked, pending_entries);
    if (mismatch_count == 0 && pending_entries == 0) begin
      $display("sorted_unique_list_builder_top test passed");
    end else begin
      $display("sorted_unique_list_builder_top test failed");
    end
    $finish;
  end

endmodule
